@@ design/thm_pkg.sv @@
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types, codes and the seven-segment digit table for the thermometer.
// ----------------------------------------------------------------------------
package thm_pkg;

  localparam logic [1:0] ErrOk    = 2'd0;
  localparam logic [1:0] ErrFault = 2'd1;
  localparam logic [1:0] ErrRange = 2'd2;

  localparam logic [6:0] MinusSeg = 7'b0000001;
  localparam logic [1:0] UnitC    = 2'b01;
  localparam logic [1:0] UnitF    = 2'b10;

  // classified item passed from the front end to the back end
  typedef struct packed {
    logic [1:0] err;
    logic       is_f;
    logic       neg;
    logic [9:0] magc;
  } thm_item_t;

  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0001100;
      4'd2:    s = 7'b0110111;
      4'd3:    s = 7'b0011111;
      4'd4:    s = 7'b1001101;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1111011;
      4'd7:    s = 7'b0001110;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1011111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

@@ design/thm_front.sv @@
// ----------------------------------------------------------------------------
// thm_front
// Accepts raw readings, converts to signed tenths Celsius and flags faults.
// ----------------------------------------------------------------------------
module thm_front import thm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sensor_reading_i,
  input  logic        fahrenheit_select_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output thm_item_t   item_o
);

  logic        valid_q;
  thm_item_t   item_q, item_d;
  logic [9:0]  whole;
  logic        fault;
  logic [10:0] t;
  logic        neg;
  logic [9:0]  mag;

  assign whole = sensor_reading_i[15:6];
  assign fault = (whole >= 10'd1000) && (sensor_reading_i[5:0] != 6'd0);
  assign t     = {1'b0, whole} - 11'd500 + {10'd0, sensor_reading_i[5]};
  assign neg   = t[10];
  assign mag   = neg ? 10'(-t) : t[9:0];

  always_comb begin
    if (fault) begin
      item_d = '{err: ErrFault, is_f: 1'b0, neg: 1'b0, magc: 10'd0};
    end else begin
      item_d.is_f = fahrenheit_select_i;
      item_d.neg  = neg;
      item_d.magc = mag;
      // celsius range check; negative side never drops below -50.0
      item_d.err  = (!fahrenheit_select_i && !neg && mag > 10'd500) ? ErrRange : ErrOk;
    end
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

@@ design/thm_fifo.sv @@
// ----------------------------------------------------------------------------
// thm_fifo
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module thm_fifo import thm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  thm_item_t wr_item_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output thm_item_t rd_item_o
);

  thm_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

@@ design/thm_back.sv @@
// ----------------------------------------------------------------------------
// thm_back
// Four-stage pipeline: unit conversion, range check, digit split, segments.
// ----------------------------------------------------------------------------
module thm_back import thm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  thm_item_t   item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] display_word_o,
  output logic [1:0]  error_code_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign item_ready_o = en1;

  // stage 1: |C|*9/5 by reciprocal multiply
  logic [12:0] m9;
  logic [26:0] p1;
  logic [1:0]  s1_err_q;
  logic        s1_is_f_q, s1_neg_q;
  logic [9:0]  s1_magc_q, s1_qf_q;

  assign m9 = {item_i.magc, 3'b000} + {3'b000, item_i.magc};
  assign p1 = {14'd0, m9} * 27'd13108;

  // stage 2: fahrenheit offset and range, then |v|/10
  logic [11:0] fv;
  logic        fsign, frange, sgn2;
  logic [10:0] fmag, mag2;
  logic [1:0]  err2;
  logic [23:0] p2;
  logic [1:0]  s2_err_q;
  logic        s2_is_f_q, s2_sgn_q;
  logic [10:0] s2_mag_q;
  logic [6:0]  s2_q1_q;

  assign fv     = s1_neg_q ? (12'd320 - {2'b00, s1_qf_q}) : (12'd320 + {2'b00, s1_qf_q});
  assign fsign  = fv[11];
  assign fmag   = fsign ? 11'(-fv) : fv[10:0];
  assign frange = fsign ? (fmag > 11'd580) : (fmag > 11'd1220);
  assign mag2   = s1_is_f_q ? fmag : {1'b0, s1_magc_q};
  assign sgn2   = s1_is_f_q ? fsign : s1_neg_q;
  assign err2   = (s1_err_q != ErrOk) ? s1_err_q : ((s1_is_f_q && frange) ? ErrRange : ErrOk);
  assign p2     = {13'd0, mag2} * 24'd6554;

  // stage 3: tenths digit and |v|/100
  logic [10:0] rem0;
  logic [14:0] p3;
  logic [1:0]  s3_err_q;
  logic        s3_is_f_q, s3_sgn_q;
  logic [3:0]  s3_d0_q, s3_q2_q;
  logic [6:0]  s3_q1_q;

  assign rem0 = s2_mag_q - ({1'b0, s2_q1_q, 3'b000} + {3'b000, s2_q1_q, 1'b0});
  assign p3   = {8'd0, s2_q1_q} * 15'd205;

  // stage 4: remaining digits and segment word
  logic [6:0]  rem1;
  logic        q3, tens_on;
  logic [3:0]  d2;
  logic [6:0]  seg_tens, seg_hund;
  logic [29:0] word;
  logic [29:0] word_q;
  logic [1:0]  err_q;

  assign rem1    = s3_q1_q - ({s3_q2_q, 3'b000} + {2'b00, s3_q2_q, 1'b0});
  assign q3      = (s3_q2_q >= 4'd10);
  assign d2      = q3 ? (s3_q2_q - 4'd10) : s3_q2_q;
  assign tens_on = (s3_q2_q != 4'd0);

  always_comb begin
    seg_tens = 7'd0;
    seg_hund = 7'd0;
    if (tens_on) begin
      seg_tens = seg7(d2);
      if (q3) seg_hund = seg7(4'd1);
      if (s3_sgn_q) seg_hund = seg_hund | MinusSeg;
    end else if (s3_sgn_q) begin
      seg_tens = MinusSeg;
    end
    word = {(s3_is_f_q ? UnitF : UnitC), seg_hund, seg_tens,
            seg7(rem1[3:0]), seg7(s3_d0_q)};
    if (s3_err_q == ErrRange) word = 30'd0;
  end

  assign out_valid_o    = v4_q;
  assign display_word_o = word_q;
  assign error_code_o   = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= item_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_err_q  <= item_i.err;
      s1_is_f_q <= item_i.is_f;
      s1_neg_q  <= item_i.neg;
      s1_magc_q <= item_i.magc;
      s1_qf_q   <= p1[25:16];
    end
    if (en2) begin
      s2_err_q  <= err2;
      s2_is_f_q <= s1_is_f_q;
      s2_sgn_q  <= sgn2;
      s2_mag_q  <= mag2;
      s2_q1_q   <= p2[22:16];
    end
    if (en3) begin
      s3_err_q  <= s2_err_q;
      s3_is_f_q <= s2_is_f_q;
      s3_sgn_q  <= s2_sgn_q;
      s3_d0_q   <= rem0[3:0];
      s3_q1_q   <= s2_q1_q;
      s3_q2_q   <= p3[14:11];
    end
    if (en4) begin
      word_q <= word;
      err_q  <= s3_err_q;
    end
  end

endmodule

@@ design/sensor_to_seven_segment_thermometer.sv @@
// ----------------------------------------------------------------------------
// sensor_to_seven_segment_thermometer
// Raw sensor reading to seven-segment display word with unit and error code.
// ----------------------------------------------------------------------------
// channel  signals                                       dir
// in       in_valid_i/in_ready_o, sensor_reading_i,      in
//          fahrenheit_select_i
// out      out_valid_o/out_ready_i, display_word_o,      out
//          error_code_o
//
// one item per cycle sustained while the output is not stalled; from accept to
// output valid an item passes the front register, then one queue slot and the
// four back-end stages. reset clears all valid bits and queue pointers. a stall
// at the output fills the back end, then the two-entry queue, then the front
// register before in_ready_o drops.
// ----------------------------------------------------------------------------
module sensor_to_seven_segment_thermometer import thm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sensor_reading_i,
  input  logic        fahrenheit_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] display_word_o,
  output logic [1:0]  error_code_o
);

  logic      fr_valid, fr_ready;
  thm_item_t fr_item;
  logic      bk_valid, bk_ready;
  thm_item_t bk_item;

  thm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sensor_reading_i,
    .fahrenheit_select_i,
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  thm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_item_o  (bk_item)
  );

  thm_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o,
    .out_ready_i,
    .display_word_o,
    .error_code_o
  );

endmodule
